>>> src/lqc_pkg.sv
// Package with shared widths, request and status codes and cell control type.
`timescale 1ns / 1ps
`default_nettype none
package lqc_pkg;

  // Default sizing of the queue.
  localparam int unsigned DefDepth   = 8;
  localparam int unsigned DefIdWidth = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned ReqW    = 2;
  localparam int unsigned TicketW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;

  // Request kinds; the fourth code is a no-op.
  typedef enum logic [ReqW-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_CANCEL = 2'd2
  } req_e;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Operation broadcast from the control to every slot cell.
  typedef struct packed {
    logic enq;
    logic cancel;
    logic empty;
  } cell_op_t;

endpackage
`default_nettype wire

>>> src/lqc_if.sv
// Valid/ready channel interfaces for queue requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface lqc_req_if;
  logic                        valid;
  logic                        ready;
  logic [lqc_pkg::ReqW-1:0]    req_type;
  logic [lqc_pkg::TicketW-1:0] ticket_id;

  modport source (output valid, output req_type, output ticket_id, input ready);
  modport sink (input valid, input req_type, input ticket_id, output ready);
endinterface

interface lqc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lqc_pkg::StatusW-1:0] status;
  logic [lqc_pkg::TicketW-1:0] out_ticket;
  logic [lqc_pkg::CountW-1:0]  pending_count;

  modport source (output valid, output status, output out_ticket, output pending_count,
                  input ready);
  modport sink (input valid, input status, input out_ticket, input pending_count,
                output ready);
endinterface
`default_nettype wire

>>> src/lqc_cell.sv
// One queue slot: holds an identifier, matches it and shifts from its upper neighbor.
`timescale 1ns / 1ps
`default_nettype none
module lqc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned PTR_W    = 3,
  parameter int unsigned ID_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire lqc_pkg::cell_op_t op_i,
  input  wire [PTR_W-1:0]      head_i,
  input  wire [PTR_W-1:0]      tail_i,
  input  wire [ID_WIDTH-1:0]   id_i,
  input  wire                  found_i,
  input  wire [ID_WIDTH-1:0]   next_data_i,
  output logic                 found_o,
  output logic [ID_WIDTH-1:0]  data_o,
  output logic [ID_WIDTH-1:0]  rd_data_o
);
  import lqc_pkg::*;

  localparam logic [PTR_W-1:0] IdxP  = PTR_W'(CELL_IDX);
  localparam logic [PTR_W-1:0] PrevP = PTR_W'(CELL_IDX - 1);

  logic [ID_WIDTH-1:0] data_q, data_d;
  logic                in_range;
  logic                match;
  logic                shift;
  logic                wr;

  // Occupancy, match and the first-match chain.
  always_comb begin
    in_range = !op_i.empty && (IdxP >= head_i) && (IdxP <= tail_i);
    match    = op_i.cancel && in_range && (data_q == id_i);
    found_o  = found_i || match;
    shift    = op_i.cancel && found_o && (IdxP < tail_i);
  end

  // Write on enqueue: slot 0 of an empty queue, else the slot past the tail.
  always_comb begin
    if (op_i.empty) begin
      wr = op_i.enq && (CELL_IDX == 0);
    end else begin
      wr = op_i.enq && (CELL_IDX != 0) && (tail_i == PrevP);
    end
  end

  // Next slot contents.
  always_comb begin
    if (wr) begin
      data_d = id_i;
    end else if (shift) begin
      data_d = next_data_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Data handed down to the lower neighbor, and the head read contribution.
  assign data_o    = data_q;
  assign rd_data_o = (!op_i.empty && head_i == IdxP) ? data_q : '0;

endmodule
`default_nettype wire

>>> src/linear_queue_with_cancel.sv
// Linear ticket queue with dequeue and cancel by identifier, built as a chain of slot cells.
//
// Requests arrive on req_i (req_type, ticket_id) with valid/ready. Enqueue appends at the
// tail and answers full once the tail sits in the last slot, even after dequeues. Dequeue
// returns the head entry; cancel removes the first entry equal to ticket_id, and the cells
// above it shift down one place in the same cycle. Every transaction on req_i gives exactly
// one response on rsp_o (status, out_ticket, pending_count).
// The response sits in an output register from the cycle after the request is taken. Throughput
// is one request per cycle while the receiver keeps up; the critical path is the identifier
// compare in every cell and the first-match chain running across all DEPTH cells.
// If the receiver stalls, the response is held and req_i.ready stays low until it is taken;
// a request is accepted in the same cycle that the held response leaves.
// Reset empties the queue at once (head and tail to slot 0) and clears the response valid;
// slot contents are not cleared since no request can read an unwritten slot.
// Request kind 3 changes nothing and answers done with the current count.
`timescale 1ns / 1ps
`default_nettype none
module linear_queue_with_cancel #(
  parameter int unsigned DEPTH    = lqc_pkg::DefDepth,
  parameter int unsigned ID_WIDTH = lqc_pkg::DefIdWidth
) (
  input  wire clk_i,
  input  wire rst_ni,
  lqc_req_if.sink   req_i,
  lqc_rsp_if.source rsp_o
);
  import lqc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastP = PtrW'(DEPTH - 1);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic            empty_q, empty_d;
  logic            fire;
  logic [ID_WIDTH-1:0] id;
  cell_op_t        op;

  logic [DEPTH:0]      found_chain;
  logic [ID_WIDTH-1:0] cell_data [DEPTH+1];
  logic [ID_WIDTH-1:0] cell_rd [DEPTH];
  logic [ID_WIDTH-1:0] head_data;

  logic                out_valid_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [TicketW-1:0]  ticket_q, ticket_d;
  logic [CountW-1:0]   count_q;
  logic [CntW-1:0]     count_d;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign id          = ID_WIDTH'(req_i.ticket_id);

  // Broadcast operation to the cells, only on an accepted transaction.
  always_comb begin
    op.enq    = fire && (req_i.req_type == REQ_ENQ);
    op.cancel = fire && (req_i.req_type == REQ_CANCEL);
    op.empty  = empty_q;
  end

  // Row of slot cells; the match chain runs upward, data moves downward.
  assign found_chain[0]   = 1'b0;
  assign cell_data[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lqc_cell #(
      .CELL_IDX (g),
      .PTR_W    (PtrW),
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .head_i      (head_q),
      .tail_i      (tail_q),
      .id_i        (id),
      .found_i     (found_chain[g]),
      .next_data_i (cell_data[g+1]),
      .found_o     (found_chain[g+1]),
      .data_o      (cell_data[g]),
      .rd_data_o   (cell_rd[g])
    );
  end

  // Head entry read: at most one cell drives a nonzero value.
  always_comb begin
    head_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      head_data = head_data | cell_rd[i];
    end
  end

  // Pointer update and response.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    status_d = ST_DONE;
    ticket_d = '0;
    case (req_i.req_type)
      REQ_ENQ: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
        end else if (tail_q == LastP) begin
          status_d = ST_FULL;
        end else begin
          tail_d = tail_q + 1'b1;
        end
      end
      REQ_DEQ: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else begin
          ticket_d = TicketW'(head_data);
          if (head_q >= tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_q + 1'b1;
          end
        end
      end
      REQ_CANCEL: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else if (!found_chain[DEPTH]) begin
          status_d = ST_NOTFOUND;
        end else begin
          ticket_d = TicketW'(id);
          if (tail_q <= head_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            tail_d = tail_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (empty_d) begin
      count_d = '0;
    end else begin
      count_d = CntW'(tail_d) - CntW'(head_d) + 1'b1;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (fire) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      ticket_q <= ticket_d;
      count_q  <= CountW'(count_d);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.out_ticket    = ticket_q;
  assign rsp_o.pending_count = count_q;

`ifndef ASSERT_OFF
  // An empty queue always has both pointers on the first slot.
  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0) && (tail_q == '0))
    else $error("empty queue with pointers off slot 0");

  // A non-empty queue never has its head past its tail.
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (head_q <= tail_q))
    else $error("head past tail");

  // Enqueue into an empty queue leaves exactly one entry in slot 0.
  a_first_enq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req_i.req_type == REQ_ENQ && empty_q) |=> !empty_q && (tail_q == '0))
    else $error("first enqueue misplaced");

  // A response reporting an empty queue carries no ticket and a zero count.
  a_empty_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> (ticket_q == '0) && (count_q == '0))
    else $error("empty response with ticket or count");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the linear ticket queue with cancel by identifier.
`timescale 1ns / 1ps
module testbench;
  import lqc_pkg::*;

  localparam int unsigned Depth       = DefDepth;
  localparam logic [ReqW-1:0] ReqNop  = 2'd3;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PoolSize    = 8;

  typedef struct packed {
    status_e            status;
    logic [TicketW-1:0] ticket;
    logic [CountW-1:0]  count;
  } rsp_t;

  typedef struct {
    logic [ReqW-1:0]    kind;
    logic [TicketW-1:0] id;
    bit                 fixed;
    rsp_t               rsp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lqc_req_if req_if ();
  lqc_rsp_if rsp_if ();

  linear_queue_with_cancel i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the queue that the predictor keeps.
  logic [TicketW-1:0] q_slots [Depth];
  int unsigned        q_head  = 0;
  int unsigned        q_tail  = 0;
  bit                 q_empty = 1'b1;

  // Responses still owed by the block, oldest first.
  rsp_t        expected_rsps [$];
  int unsigned err_cnt = 0;

  // Knobs shared between the stimulus, receiver and monitor processes.
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  bit                 hold_rsp      = 1'b0;
  bit                 row_fixed;
  rsp_t               row_rsp;
  logic [TicketW-1:0] id_pool [PoolSize];
  stim_row_t          dir_rows [$];

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void empty_queue();
    q_empty = 1'b1;
    q_head  = 0;
    q_tail  = 0;
  endfunction

  // Applies one request to the shadow queue and returns the response it must produce.
  function automatic rsp_t predict_response(logic [ReqW-1:0] kind, logic [TicketW-1:0] id);
    rsp_t        r;
    int unsigned hit;
    bit          found;
    r     = '{status: ST_DONE, ticket: '0, count: '0};
    hit   = 0;
    found = 1'b0;
    if (kind == REQ_ENQ) begin
      if (q_empty) begin
        q_head     = 0;
        q_tail     = 0;
        q_slots[0] = id;
        q_empty    = 1'b0;
      end else if (q_tail >= Depth - 1) begin
        r.status = ST_FULL;
      end else begin
        q_tail++;
        q_slots[q_tail] = id;
      end
    end else if (kind == REQ_DEQ) begin
      if (q_empty) begin
        r.status = ST_EMPTY;
      end else begin
        r.ticket = q_slots[q_head];
        if (q_head >= q_tail) empty_queue();
        else q_head++;
      end
    end else if (kind == REQ_CANCEL) begin
      if (q_empty) begin
        r.status = ST_EMPTY;
      end else begin
        // The first match from head to tail wins.
        for (int unsigned i = q_head; i <= q_tail; i++) begin
          if (!found && q_slots[i] == id) begin
            hit   = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.ticket = id;
          for (int unsigned i = hit; i < q_tail; i++) q_slots[i] = q_slots[i + 1];
          if (q_tail <= q_head) empty_queue();
          else q_tail--;
        end
      end
    end
    r.count = q_empty ? '0 : CountW'(q_tail - q_head + 1);
    return r;
  endfunction

  function automatic stim_row_t row_of(logic [ReqW-1:0] kind, logic [TicketW-1:0] id,
                                       bit fixed = 1'b0, status_e st = ST_DONE,
                                       logic [TicketW-1:0] tk = '0,
                                       logic [CountW-1:0] cnt = '0);
    stim_row_t r;
    r.kind  = kind;
    r.id    = id;
    r.fixed = fixed;
    r.rsp   = '{status: st, ticket: tk, count: cnt};
    return r;
  endfunction

  // Mostly identifiers from a small pool so that cancels find their target.
  function automatic logic [TicketW-1:0] pick_ticket();
    if ($urandom_range(0, 99) < 60) return id_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom();
  endfunction

  // Offers one request and returns at the edge where the transaction is taken.
  task automatic send_request(stim_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= row.kind;
    req_if.ticket_id <= row.id;
    row_fixed        <= row.fixed;
    row_rsp          <= row.rsp;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Random traffic in blocks that lean toward filling or toward draining the queue.
  task automatic run_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    stim_row_t   row;
    int unsigned enq_w;
    int unsigned pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    enq_w         = 45;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) enq_w = $urandom_range(20, 75);
      pick = $urandom_range(0, 99);
      row  = row_of(REQ_ENQ, pick_ticket());
      if (pick >= 95) row.kind = ReqNop;
      else if (pick >= enq_w) row.kind = ((pick - enq_w) % 2) ? REQ_DEQ : REQ_CANCEL;
      send_request(row);
    end
  endtask

  // Response checker and request predictor, sampled at each rising edge.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    rsp_t got;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = status_e'(rsp_if.status);
        got.ticket = rsp_if.out_ticket;
        got.count  = rsp_if.pending_count;
        if (expected_rsps.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("unexpected response: status %0d ticket %h count %0d",
                     got.status, got.ticket, got.count);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.status !== exp_rsp.status || got.ticket !== exp_rsp.ticket ||
              got.count !== exp_rsp.count) begin
            err_cnt++;
            if (err_cnt <= MaxReports)
              $display("mismatch: expected status %0d ticket %h count %0d,",
                       exp_rsp.status, exp_rsp.ticket, exp_rsp.count,
                       " got status %0d ticket %h count %0d",
                       got.status, got.ticket, got.count);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        exp_rsp = predict_response(req_if.req_type, req_if.ticket_id);
        expected_rsps.push_back(row_fixed ? row_rsp : exp_rsp);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin : receiver
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[linear_queue_with_cancel] ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin : stimulus
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_ENQ;
    req_if.ticket_id <= '0;
    row_fixed        <= 1'b0;
    row_rsp          <= '0;
    rst_ni           <= 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int unsigned k = 2; k < PoolSize; k++) id_pool[k] = $urandom();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests on the empty queue, then fill it to the last slot.
    dir_rows.push_back(row_of(REQ_DEQ,    32'h0,        1'b1, ST_EMPTY, 32'h0, 4'd0));
    dir_rows.push_back(row_of(REQ_CANCEL, 32'hFFFFFFFF, 1'b1, ST_EMPTY, 32'h0, 4'd0));
    dir_rows.push_back(row_of(ReqNop,     32'hFFFFFFFF, 1'b1, ST_DONE,  32'h0, 4'd0));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h0,        1'b1, ST_DONE,  32'h0, 4'd1));
    dir_rows.push_back(row_of(REQ_ENQ,    32'hFFFFFFFF));
    dir_rows.push_back(row_of(REQ_ENQ,    32'hA5A5A5A5));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h5A5A5A5A));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h12345678));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h00000001));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h80000000));
    dir_rows.push_back(row_of(REQ_ENQ,    32'hA5A5A5A5));
    dir_rows.push_back(row_of(REQ_ENQ,    32'hDEADBEEF, 1'b1, ST_FULL,  32'h0, 4'd8));
    // Cancel with a duplicate identifier removes the first copy only.
    dir_rows.push_back(row_of(REQ_CANCEL, 32'hA5A5A5A5));
    dir_rows.push_back(row_of(REQ_CANCEL, 32'h77777777, 1'b1, ST_NOTFOUND, 32'h0, 4'd7));
    dir_rows.push_back(row_of(REQ_DEQ,    32'h0));
    dir_rows.push_back(row_of(REQ_DEQ,    32'hFFFFFFFF));
    // Tail reaches the last slot again: full with free slots below the head.
    dir_rows.push_back(row_of(REQ_ENQ,    32'h00000011));
    dir_rows.push_back(row_of(REQ_ENQ,    32'h00000022, 1'b1, ST_FULL,  32'h0, 4'd6));
    // Cancel at the tail, at the head, then drain down to empty.
    dir_rows.push_back(row_of(REQ_CANCEL, 32'h00000011));
    dir_rows.push_back(row_of(REQ_CANCEL, 32'h5A5A5A5A));
    dir_rows.push_back(row_of(REQ_DEQ,    32'h0));
    dir_rows.push_back(row_of(REQ_CANCEL, 32'hA5A5A5A5));
    dir_rows.push_back(row_of(REQ_DEQ,    32'h0));
    dir_rows.push_back(row_of(REQ_CANCEL, 32'h80000000));
    dir_rows.push_back(row_of(REQ_DEQ,    32'h0,        1'b1, ST_EMPTY, 32'h0, 4'd0));
    foreach (dir_rows[k]) send_request(dir_rows[k]);

    run_random(640, 15, 88);
    run_random(640, 88, 15);
    // The receiver holds off for a while as this phase starts so the request channel stalls.
    hold_rsp = 1'b1;
    run_random(645, 0, 0);
    req_if.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_rsps.size() == 0)
      $display("[linear_queue_with_cancel] OK");
    else
      $display("[linear_queue_with_cancel] ERROR");
    $finish;
  end

endmodule
